/* rtl/core/dvru_pkg.sv */
// ----------------------------------------------------------------------------
// Distance-vector route update package
// Shared types, field widths, command, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

    localparam int ADDR_W     = 32;
    localparam int COST_W     = 8;
    localparam int CMD_W      = 2;
    localparam int RIDX_W     = 6;
    localparam int OIDX_W     = 6;
    localparam int OCNT_W     = 7;
    localparam int OWN_CNT_W  = 3;
    localparam int OWN_IP_NUM = 4;
    localparam int CFG_ADDR_W = 3;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_TUSER_W = 3;

    localparam logic [COST_W-1:0] COST_MAX = 8'hFF;

    // Commands carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_MERGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP_0     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP_1     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP_2     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP_3     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_IP_COUNT = 3'd4;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_UPDATED    = 3'd1,
        ST_UNCHANGED  = 3'd2,
        ST_LOOP       = 3'd3,
        ST_FULL       = 3'd4,
        ST_READ_OK    = 3'd5,
        ST_READ_EMPTY = 3'd6
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [ADDR_W-1:0] iface;
        logic [COST_W-1:0] cost;
    } route_t;

    typedef logic [OWN_IP_NUM-1:0][ADDR_W-1:0] own_ip_t;

endpackage

`default_nettype wire

/* rtl/core/distance_vector_route_update_core.sv */
// ----------------------------------------------------------------------------
// Distance-vector route update core
// Keeps a routing table and merges advertised routes, loads local routes and
// serves table reads, one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_axis channel, one result per item leaves on m_axis.
//   The own interface addresses and their count are written on the cfg port
//   while the core is idle.
//   A merge or local load scans the table for the destination, one stored
//   entry per cycle through the table RAM read port, and stops early when the
//   destination is found; it then writes back. A read fetches its entry through
//   the same read port. The result is registered at the write-back and appears
//   in the cycle after it.
//   The result sits in an output register, so the next transfer is accepted
//   while the receiver stalls; a finished item then waits in its write-back
//   cycle until the output register frees up.
//   Reset empties the table (entry count zero) and clears the configuration;
//   the table RAM itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_route_update_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // dest_ip, adv_cost, adv_next_hop, neighbor_ip, receive_interface, read_index
    input  wire [dvru_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // command
    input  wire [dvru_pkg::CMD_W-1:0]             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // entry_index, entry_dest, entry_next_hop, entry_interface, entry_cost,
    // entry_count
    output logic [dvru_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [dvru_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    input  wire                                   cfg_we,
    input  wire [dvru_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire [dvru_pkg::ADDR_W-1:0]            cfg_wdata
);
    import dvru_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    own_ip_t              own_ip_reg;
    logic [OWN_CNT_W-1:0] own_cnt_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    route_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    route_t           wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_OWN_IP_0:     own_ip_reg[0] <= cfg_wdata;
                CFG_OWN_IP_1:     own_ip_reg[1] <= cfg_wdata;
                CFG_OWN_IP_2:     own_ip_reg[2] <= cfg_wdata;
                CFG_OWN_IP_3:     own_ip_reg[3] <= cfg_wdata;
                CFG_OWN_IP_COUNT: own_cnt_reg   <= cfg_wdata[OWN_CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    dvru_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .own_ip        (own_ip_reg),
        .own_ip_count  (own_cnt_reg),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    dvru_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

/* rtl/core/dvru_table.sv */
// ----------------------------------------------------------------------------
// Route table memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                             clk,
    input  wire                             rd_en,
    input  wire [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    output dvru_pkg::route_t                rd_data,
    input  wire                             wr_en,
    input  wire [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
    input  wire dvru_pkg::route_t           wr_data
);
    import dvru_pkg::*;

    route_t mem [TABLE_DEPTH];
    route_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/dvru_ctrl.sv */
// ----------------------------------------------------------------------------
// Route update sequencer
// Scans the table for a destination, decides the update and writes it back.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire [dvru_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    input  wire [dvru_pkg::CMD_W-1:0]             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [dvru_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [dvru_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
    input  wire dvru_pkg::own_ip_t                own_ip,
    input  wire [dvru_pkg::OWN_CNT_W-1:0]         own_ip_count,
    output logic                                  rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
    input  wire dvru_pkg::route_t                 rd_data,
    output logic                                  wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
    output dvru_pkg::route_t                      wr_data
);
    import dvru_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_RD     = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [COST_W-1:0] cost_reg;
    logic [ADDR_W-1:0] advhop_reg;
    logic [ADDR_W-1:0] nbr_reg;
    logic [ADDR_W-1:0] rif_reg;
    logic [RIDX_W-1:0] ridx_reg;

    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  issue_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  hit_idx_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;
    logic [OUT_TUSER_W-1:0] out_tuser_reg;

    logic              in_fire;
    logic [CMD_W-1:0]  in_cmd;
    logic [COST_W-1:0] in_cost;
    logic [COST_W-1:0] in_cost_eff;

    logic              match;
    logic              scan_done;
    logic              out_free;
    logic              fin_fire;

    logic [OWN_CNT_W-1:0] own_cnt_clamp;
    logic                 own_hit;
    logic                 read_ok;
    logic                 cheaper;
    logic                 table_full;
    route_t               new_rec;

    status_t          fin_status;
    logic [OIDX_W-1:0] fin_idx;
    route_t           fin_rec;
    logic             fin_we;
    logic [IDX_W-1:0] fin_waddr;
    logic             fin_inc;
    logic [CNT_W-1:0] used_next;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser;
    assign in_cost       = s_axis_tdata[39:32];
    // A merged cost is one hop more than advertised, held at the maximum.
    assign in_cost_eff   = (in_cmd != CMD_MERGE) ? in_cost :
                           (in_cost == COST_MAX) ? COST_MAX : in_cost + 8'd1;

    assign match     = (state_reg == S_SCAN) && pend_reg && (rd_data.dest == dest_reg);
    assign scan_done = (issue_reg == used_reg) && !match;

    // Reads stop on a hit so that the read register keeps the matched route.
    assign rd_en   = ((state_reg == S_SCAN) && (issue_reg != used_reg) && !match)
                     || (state_reg == S_RD);
    assign rd_addr = (state_reg == S_RD) ? IDX_W'(ridx_reg) : issue_reg[IDX_W-1:0];

    assign out_free = !out_valid_reg || m_axis_tready;
    assign fin_fire = (state_reg == S_FINISH) && out_free;

    assign own_cnt_clamp = (own_ip_count > OWN_CNT_W'(OWN_IP_NUM)) ?
                           OWN_CNT_W'(OWN_IP_NUM) : own_ip_count;

    always_comb
    begin
        own_hit = 1'b0;
        for (int i = 0; i < OWN_IP_NUM; i++)
        begin
            if ((OWN_CNT_W'(i) < own_cnt_clamp) && (own_ip[i] == advhop_reg))
            begin
                own_hit = 1'b1;
            end
        end
    end

    assign read_ok    = 32'(ridx_reg) < 32'(used_reg);
    assign cheaper    = cost_reg < rd_data.cost;
    assign table_full = used_reg >= CNT_W'(TABLE_DEPTH);
    assign new_rec    = '{dest: dest_reg, hop: nbr_reg, iface: rif_reg, cost: cost_reg};

    always_comb
    begin
        fin_status = ST_UNCHANGED;
        fin_idx    = '0;
        fin_rec    = '0;
        fin_we     = 1'b0;
        fin_waddr  = hit_idx_reg;
        fin_inc    = 1'b0;
        case (cmd_reg) inside
            CMD_READ:
            begin
                fin_idx = ridx_reg;
                if (read_ok)
                begin
                    fin_status = ST_READ_OK;
                    fin_rec    = rd_data;
                end
                else
                begin
                    fin_status = ST_READ_EMPTY;
                end
            end
            CMD_MERGE, CMD_LOCAL:
            begin
                if (found_reg)
                begin
                    fin_idx = OIDX_W'(hit_idx_reg);
                    if ((cmd_reg == CMD_LOCAL) || (cheaper && !own_hit))
                    begin
                        fin_status = ST_UPDATED;
                        fin_rec    = new_rec;
                        fin_we     = 1'b1;
                    end
                    else
                    begin
                        fin_status = cheaper ? ST_LOOP : ST_UNCHANGED;
                        fin_rec    = rd_data;
                    end
                end
                else if (table_full)
                begin
                    fin_status = ST_FULL;
                end
                else
                begin
                    fin_status = ST_INSERTED;
                    fin_idx    = OIDX_W'(used_reg);
                    fin_rec    = new_rec;
                    fin_we     = 1'b1;
                    fin_waddr  = used_reg[IDX_W-1:0];
                    fin_inc    = 1'b1;
                end
            end
            default:
            begin
                fin_status = ST_UNCHANGED;
            end
        endcase
    end

    assign used_next = used_reg + CNT_W'(fin_inc);

    assign wr_en   = fin_fire && fin_we;
    assign wr_addr = fin_waddr;
    assign wr_data = fin_rec;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_READ)
                    begin
                        state_next = S_RD;
                    end
                    else if ((in_cmd == CMD_MERGE) || (in_cmd == CMD_LOCAL))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (match || scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_RD:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                issue_reg <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (fin_fire)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= in_cmd;
            dest_reg   <= s_axis_tdata[31:0];
            cost_reg   <= in_cost_eff;
            advhop_reg <= s_axis_tdata[71:40];
            nbr_reg    <= s_axis_tdata[103:72];
            rif_reg    <= s_axis_tdata[135:104];
            ridx_reg   <= s_axis_tdata[141:136];
        end
        if (rd_en)
        begin
            pend_idx_reg <= issue_reg[IDX_W-1:0];
        end
        if (match)
        begin
            hit_idx_reg <= pend_idx_reg;
        end
        if (fin_fire)
        begin
            out_tdata_reg <= {3'b000, OCNT_W'(used_next), fin_rec.cost, fin_rec.iface,
                              fin_rec.hop, fin_rec.dest, fin_idx};
            out_tuser_reg <= fin_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

endmodule

`default_nettype wire

/* rtl/core/dvru_checker.sv */
// ----------------------------------------------------------------------------
// Route update port checker
// Watches the result channel of the core and checks its results over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_checker (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               m_axis_tvalid,
    input  wire                               m_axis_tready,
    input  wire [dvru_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire [dvru_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import dvru_pkg::*;

    // A stalled result keeps its valid and its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // A read of an empty slot carries no route contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_READ_EMPTY) |->
            (m_axis_tdata[109:6] == '0))
        else $error("empty read returned route data");

    // A dropped insertion points at slot zero with no route contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
            (m_axis_tdata[109:0] == '0))
        else $error("full table result carries data");

endmodule

bind distance_vector_route_update_core dvru_checker u_dvru_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Distance-vector route update core testbench
// Drives route items on the input stream and checks every result on the output
// stream against a predictor that keeps its own routing table and node addresses,
// or against a fixed result for some directed items. A short table of directed
// items comes first, then phases of random items, each with new node addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import dvru_pkg::*;

    localparam int SLOTS = 64;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PHASES = 5;
    localparam int POOL_SIZE = 80;
    localparam int EXP_DEPTH = 64;
    localparam int ROW_MAX = 32;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] dest;
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] adv_hop;
        logic [ADDR_W-1:0] nbr;
        logic [ADDR_W-1:0] rif;
        logic [RIDX_W-1:0] ridx;
    } route_item_t;

    typedef struct {
        status_t           status;
        logic [OIDX_W-1:0] index;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [ADDR_W-1:0] iface;
        logic [COST_W-1:0] cost;
        logic [OCNT_W-1:0] count;
    } route_reply_t;

    typedef struct {
        route_item_t  item;
        bit           typed;
        route_reply_t reply;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // dest_ip, adv_cost, adv_next_hop, neighbor_ip, receive_interface, read_index
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    // command
    logic [CMD_W-1:0]        s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // entry_index, entry_dest, entry_next_hop, entry_interface, entry_cost,
    // entry_count
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // status
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    cfg_we;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [ADDR_W-1:0]       cfg_wdata;

    // Predictor copy of the routing table and node configuration.
    logic [ADDR_W-1:0]    route_dest [SLOTS];
    logic [ADDR_W-1:0]    route_hop [SLOTS];
    logic [ADDR_W-1:0]    route_iface [SLOTS];
    logic [COST_W-1:0]    route_cost [SLOTS];
    int                   route_used;
    logic [ADDR_W-1:0]    node_addr [OWN_IP_NUM];
    logic [OWN_CNT_W-1:0] node_addr_count;

    // Outstanding expectations, oldest at exp_head.
    route_reply_t  expected_replies [EXP_DEPTH];
    int            exp_head = 0;
    int            exp_tail = 0;
    directed_row_t directed_rows [ROW_MAX];
    int            row_count = 0;
    logic [ADDR_W-1:0] dest_pool [POOL_SIZE];

    int  fail_count;
    int  items_sent;
    int  replies_seen;
    bit  send_calm;
    bit  recv_calm;

    distance_vector_route_update_core #(
        .TABLE_DEPTH(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    initial
    begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic route_item_t make_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] dest,
                                              logic [COST_W-1:0] cost,
                                              logic [ADDR_W-1:0] adv_hop,
                                              logic [ADDR_W-1:0] nbr, logic [ADDR_W-1:0] rif,
                                              logic [RIDX_W-1:0] ridx);
        route_item_t it;
        it.cmd = cmd;
        it.dest = dest;
        it.cost = cost;
        it.adv_hop = adv_hop;
        it.nbr = nbr;
        it.rif = rif;
        it.ridx = ridx;
        return it;
    endfunction

    function automatic route_reply_t make_reply(status_t st, logic [OIDX_W-1:0] index,
                                                logic [ADDR_W-1:0] dest,
                                                logic [ADDR_W-1:0] hop,
                                                logic [ADDR_W-1:0] iface,
                                                logic [COST_W-1:0] cost,
                                                logic [OCNT_W-1:0] count);
        route_reply_t r;
        r.status = st;
        r.index = index;
        r.dest = dest;
        r.hop = hop;
        r.iface = iface;
        r.cost = cost;
        r.count = count;
        return r;
    endfunction

    function automatic void add_row(route_item_t item, bit typed, route_reply_t reply);
        directed_rows[row_count].item = item;
        directed_rows[row_count].typed = typed;
        directed_rows[row_count].reply = reply;
        row_count++;
    endfunction

    // Result for a slot, with the slot contents after the item, or zeros.
    function automatic route_reply_t slot_reply(status_t st, int slot, bit fill);
        if (fill)
            return make_reply(st, slot[OIDX_W-1:0], route_dest[slot], route_hop[slot],
                              route_iface[slot], route_cost[slot], route_used[OCNT_W-1:0]);
        else
            return make_reply(st, slot[OIDX_W-1:0], '0, '0, '0, '0, route_used[OCNT_W-1:0]);
    endfunction

    function automatic route_reply_t predict_route(route_item_t it);
        int                slot;
        int                in_use;
        bit                looped;
        logic [COST_W-1:0] cost;

        if (it.cmd == CMD_READ)
        begin
            if (int'(it.ridx) < route_used)
                return slot_reply(ST_READ_OK, int'(it.ridx), 1'b1);
            return slot_reply(ST_READ_EMPTY, int'(it.ridx), 1'b0);
        end
        if (it.cmd == CMD_UNKNOWN)
            return slot_reply(ST_UNCHANGED, 0, 1'b0);

        cost = it.cost;
        if (it.cmd == CMD_MERGE)
            cost = (it.cost == COST_MAX) ? COST_MAX : it.cost + 8'd1;

        slot = -1;
        for (int i = 0; i < route_used; i++)
            if (slot < 0 && route_dest[i] == it.dest)
                slot = i;

        if (slot < 0)
        begin
            if (route_used >= SLOTS)
                return slot_reply(ST_FULL, 0, 1'b0);
            slot = route_used;
            route_dest[slot] = it.dest;
            route_hop[slot] = it.nbr;
            route_iface[slot] = it.rif;
            route_cost[slot] = cost;
            route_used++;
            return slot_reply(ST_INSERTED, slot, 1'b1);
        end

        if (it.cmd == CMD_LOCAL || cost < route_cost[slot])
        begin
            // A count above the number of address registers means all of them.
            in_use = (node_addr_count > OWN_IP_NUM) ? OWN_IP_NUM : int'(node_addr_count);
            looped = 1'b0;
            for (int i = 0; i < in_use; i++)
                if (node_addr[i] == it.adv_hop)
                    looped = 1'b1;
            if (it.cmd == CMD_MERGE && looped)
                return slot_reply(ST_LOOP, slot, 1'b1);
            route_hop[slot] = it.nbr;
            route_iface[slot] = it.rif;
            route_cost[slot] = cost;
            return slot_reply(ST_UPDATED, slot, 1'b1);
        end
        return slot_reply(ST_UNCHANGED, slot, 1'b1);
    endfunction

    task automatic send_item(route_item_t it, bit typed, route_reply_t typed_reply);
        route_reply_t predicted;
        int           gap;

        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, it.ridx, it.rif, it.nbr, it.adv_hop, it.cost, it.dest};
        s_axis_tuser <= it.cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = predict_route(it);
        expected_replies[exp_tail % EXP_DEPTH] = typed ? typed_reply : predicted;
        exp_tail++;
        items_sent++;
        if (items_sent % 64 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (exp_tail != exp_head)
            @(posedge clk);
    endtask

    task automatic configure_node(logic [ADDR_W-1:0] a0, logic [ADDR_W-1:0] a1,
                                  logic [ADDR_W-1:0] a2, logic [ADDR_W-1:0] a3,
                                  logic [OWN_CNT_W-1:0] count);
        logic [CFG_ADDR_W-1:0] regs [5];
        logic [ADDR_W-1:0]     vals [5];

        regs = '{CFG_OWN_IP_0, CFG_OWN_IP_1, CFG_OWN_IP_2, CFG_OWN_IP_3, CFG_OWN_IP_COUNT};
        vals = '{a0, a1, a2, a3, {29'd0, count}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        node_addr[0] = a0;
        node_addr[1] = a1;
        node_addr[2] = a2;
        node_addr[3] = a3;
        node_addr_count = count;
        @(posedge clk);
    endtask

    // Result side: random stalls, every transfer checked against the oldest
    // expectation.
    initial
    begin
        route_reply_t      want;
        logic [OIDX_W-1:0] got_index;
        logic [ADDR_W-1:0] got_dest;
        logic [ADDR_W-1:0] got_hop;
        logic [ADDR_W-1:0] got_iface;
        logic [COST_W-1:0] got_cost;
        logic [OCNT_W-1:0] got_count;
        int                stall;

        m_axis_tready <= 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                {got_count, got_cost, got_iface, got_hop, got_dest, got_index} =
                    m_axis_tdata[116:0];
                if (exp_tail == exp_head)
                begin
                    $error("result transfer with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_replies[exp_head % EXP_DEPTH];
                    exp_head++;
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (got_index !== want.index)
                    begin
                        $error("entry_index: expected %0d, got %0d", want.index, got_index);
                        fail_count++;
                    end
                    if (got_dest !== want.dest)
                    begin
                        $error("entry_dest: expected %h, got %h", want.dest, got_dest);
                        fail_count++;
                    end
                    if (got_hop !== want.hop)
                    begin
                        $error("entry_next_hop: expected %h, got %h", want.hop, got_hop);
                        fail_count++;
                    end
                    if (got_iface !== want.iface)
                    begin
                        $error("entry_interface: expected %h, got %h", want.iface, got_iface);
                        fail_count++;
                    end
                    if (got_cost !== want.cost)
                    begin
                        $error("entry_cost: expected %0d, got %0d", want.cost, got_cost);
                        fail_count++;
                    end
                    if (got_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, got_count);
                        fail_count++;
                    end
                end
                replies_seen++;
                if (replies_seen % 64 == 0)
                    recv_calm = ($urandom_range(0, 3) == 0);
                stall = recv_calm ? 0 : gap_len();
                if (stall > 0)
                    m_axis_tready <= 1'b0;
            end
            else if (!m_axis_tready)
            begin
                if (stall == 0)
                    m_axis_tready <= 1'b1;
                else
                    stall--;
            end
        end
    end

    initial
    begin
        route_item_t       it;
        route_reply_t      no_reply;
        logic [OWN_CNT_W-1:0] phase_count [PHASES];
        logic [ADDR_W-1:0] a [OWN_IP_NUM];
        int                window;
        int                r;

        fail_count = 0;
        items_sent = 0;
        replies_seen = 0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        route_used = 0;
        node_addr_count = '0;
        for (int i = 0; i < OWN_IP_NUM; i++)
            node_addr[i] = '0;
        no_reply = make_reply(ST_INSERTED, '0, '0, '0, '0, '0, '0);
        phase_count = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd2};

        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dest_pool[0] = 32'h0000_0000;
        dest_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            dest_pool[i] = $urandom;

        // Reads and an unknown command on the empty table, then saturation,
        // loop rejection, local overrides and empty-slot reads.
        add_row(make_item(CMD_READ, '0, '0, '0, '0, '0, 6'd0), 1'b1,
            make_reply(ST_READ_EMPTY, 6'd0, '0, '0, '0, '0, 7'd0));
        add_row(make_item(CMD_READ, '0, '0, '0, '0, '0, 6'd63), 1'b1,
            make_reply(ST_READ_EMPTY, 6'd63, '0, '0, '0, '0, 7'd0));
        add_row(make_item(CMD_UNKNOWN, 32'h1, 8'd5, '0, '0, '0, 6'd7), 1'b1,
            make_reply(ST_UNCHANGED, 6'd0, '0, '0, '0, '0, 7'd0));
        add_row(make_item(CMD_MERGE, 32'h0, 8'd255, 32'h0, 32'hFFFF_FFFF,
            32'h0A00_0001, 6'd0), 1'b1,
            make_reply(ST_INSERTED, 6'd0, 32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 8'd255, 7'd1));
        add_row(make_item(CMD_MERGE, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF,
            32'h0, 32'hFFFF_FFFF, 6'd63), 1'b1,
            make_reply(ST_INSERTED, 6'd1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'd1, 7'd2));
        add_row(make_item(CMD_MERGE, 32'h0, 8'd254, 32'h5, 32'h6, 32'h7,
            6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_MERGE, 32'h0, 8'd9, 32'hC0A8_0001, 32'h6,
            32'h7, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_MERGE, 32'h0, 8'd9, 32'h7F00_0001,
            32'h1111_1111, 32'hC0A8_0001, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_MERGE, 32'hFFFF_FFFF, 8'd0, 32'h0, 32'h9,
            32'h9, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_LOCAL, 32'hFFFF_FFFF, 8'd200, 32'h0,
            32'h2222_2222, 32'hAC10_0001, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_LOCAL, 32'h1234_5678, 8'd0, 32'h0,
            32'h3333_3333, 32'h0A00_0001, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_LOCAL, 32'h1234_5678, 8'd255, 32'h0,
            32'h4444_4444, 32'hC0A8_0001, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_MERGE, 32'h1234_5678, 8'd254, 32'h0, 32'h1,
            32'h1, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_MERGE, 32'h1234_5678, 8'd255, 32'h0, 32'h1,
            32'h1, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_READ, '0, '0, '0, '0, '0, 6'd0), 1'b0,
            no_reply);
        add_row(make_item(CMD_READ, '0, '0, '0, '0, '0, 6'd2), 1'b0,
            no_reply);
        add_row(make_item(CMD_READ, '0, '0, '0, '0, '0, 6'd3), 1'b1,
            make_reply(ST_READ_EMPTY, 6'd3, '0, '0, '0, '0, 7'd3));
        add_row(make_item(CMD_UNKNOWN, '1, '1, '1, '1, '1, '1), 1'b1,
            make_reply(ST_UNCHANGED, 6'd0, '0, '0, '0, '0, 7'd3));
        add_row(make_item(CMD_MERGE, 32'h0, 8'd0, 32'hAC10_0001, 32'h8,
            32'h8, 6'd0), 1'b0, no_reply);
        add_row(make_item(CMD_MERGE, 32'h0, 8'd0, 32'hFFFF_FFFF, '1, '1,
            '1), 1'b0, no_reply);
        add_row(make_item(CMD_READ, '1, '1, '1, '1, '1, 6'd63), 1'b1,
            make_reply(ST_READ_EMPTY, 6'd63, '0, '0, '0, '0, 7'd3));

        configure_node(32'h0A00_0001, 32'hC0A8_0001, 32'hAC10_0001, 32'h7F00_0001, 3'd3);
        for (int i = 0; i < row_count; i++)
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].reply);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase_count[phase] == 3'd7)
                a = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
            else
                for (int i = 0; i < OWN_IP_NUM; i++)
                    a[i] = $urandom;
            configure_node(a[0], a[1], a[2], a[3], phase_count[phase]);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    it.cmd = CMD_MERGE;
                else if (r < 70)
                    it.cmd = CMD_LOCAL;
                else if (r < 95)
                    it.cmd = CMD_READ;
                else
                    it.cmd = CMD_UNKNOWN;

                // The set of destinations in play widens as the run goes on,
                // so the table fills gradually and then stays full.
                window = 4 + items_sent / 12;
                if (window > POOL_SIZE - 1)
                    window = POOL_SIZE - 1;
                if ($urandom_range(0, 9) == 0)
                    it.dest = $urandom;
                else
                    it.dest = dest_pool[$urandom_range(0, window)];

                r = $urandom_range(0, 99);
                if (r < 15)
                    it.cost = 8'd255;
                else if (r < 25)
                    it.cost = 8'd254;
                else if (r < 35)
                    it.cost = 8'd0;
                else
                    it.cost = 8'($urandom_range(0, 255));

                if ($urandom_range(0, 9) < 3)
                    it.adv_hop = node_addr[$urandom_range(0, OWN_IP_NUM - 1)];
                else
                    it.adv_hop = $urandom;
                it.nbr = $urandom;
                it.rif = $urandom;
                it.ridx = 6'($urandom_range(0, 63));
                send_item(it, 1'b0, no_reply);
            end
        end

        drain();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
